// File: hdl/tcpo_pkg.sv
// Shared types and constants for the TCP option parser.
package tcpo_pkg;

  localparam int MAX_OPTION_BYTES   = 40;
  localparam int FIXED_HEADER_BYTES = 20;

  // Option kinds
  localparam logic [7:0] KIND_EOL    = 8'd0;
  localparam logic [7:0] KIND_NOP    = 8'd1;
  localparam logic [7:0] KIND_MSS    = 8'd2;
  localparam logic [7:0] KIND_WS     = 8'd3;
  localparam logic [7:0] KIND_SACKOK = 8'd4;
  localparam logic [7:0] KIND_SACK   = 8'd5;
  localparam logic [7:0] KIND_TS     = 8'd8;
  localparam logic [7:0] KIND_MD5    = 8'd19;
  localparam logic [7:0] KIND_AO     = 8'd29;
  localparam logic [7:0] KIND_TFO    = 8'd34;
  localparam logic [7:0] KIND_EXP1   = 8'd253;
  localparam logic [7:0] KIND_EXP2   = 8'd254;

  localparam logic [15:0] TFO_EXP_MAGIC = 16'hf989;
  localparam logic [3:0]  MAX_WS_SHIFT  = 4'd14;

  // Bit positions in present_mask
  localparam int PM_WS     = 0;
  localparam int PM_MSS    = 1;
  localparam int PM_SACKOK = 2;
  localparam int PM_TS     = 3;
  localparam int PM_SACK   = 4;
  localparam int PM_TFO    = 5;
  localparam int PM_MD5    = 6;
  localparam int PM_AO     = 7;

  typedef struct packed {
    logic [3:0]  window_scale;
    logic [15:0] max_segment_size;
    logic [31:0] stamp_value;
    logic [31:0] stamp_echo;
    logic [2:0]  sack_blocks;
    logic [5:0]  sack_start;
    logic [7:0]  present_mask;
    logic        bad_length_seen;
    logic        duplicate_seen;
    logic        packet_invalid;
  } tcpo_summary_t;

  typedef struct packed {
    logic [7:0] option_byte;
    logic [5:0] area_length;
    logic       first_byte;
    logic       last_byte;
  } tcpo_item_t;

endpackage

// File: hdl/tcpo_parser.sv
// Option walker: parse state, per-option checks and summary registers.
module tcpo_parser
  import tcpo_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  tcpo_item_t    item,
  output tcpo_summary_t summary
);

  typedef enum logic [1:0] {PH_KIND, PH_LEN, PH_DATA, PH_STOP} phase_t;

  phase_t      phase;
  logic [5:0]  bytes_left;
  logic [5:0]  area_position;
  logic [7:0]  current_kind;
  logic [5:0]  current_length;
  logic [5:0]  data_index;
  logic [63:0] data_capture;
  logic [3:0]  scale_reg;
  logic [15:0] mss_reg;
  logic [63:0] stamp_regs;
  logic [2:0]  sack_count;
  logic [5:0]  sack_base;
  logic [7:0]  present;
  logic        bad_flag;
  logic        dup_flag;
  logic        inv_flag;

  phase_t      phase_next;
  logic [5:0]  bytes_left_next;
  logic [5:0]  area_position_next;
  logic [7:0]  current_kind_next;
  logic [5:0]  current_length_next;
  logic [5:0]  data_index_next;
  logic [63:0] data_capture_next;
  logic [3:0]  scale_reg_next;
  logic [15:0] mss_reg_next;
  logic [63:0] stamp_regs_next;
  logic [2:0]  sack_count_next;
  logic [5:0]  sack_base_next;
  logic [7:0]  present_next;
  logic        bad_flag_next;
  logic        dup_flag_next;
  logic        inv_flag_next;

  logic        finish;
  logic [7:0]  d0;
  logic [7:0]  d1;
  logic [5:0]  n;
  logic [5:0]  n_minus2;

  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    area_position_next  = area_position;
    current_kind_next   = current_kind;
    current_length_next = current_length;
    data_index_next     = data_index;
    data_capture_next   = data_capture;
    scale_reg_next      = scale_reg;
    mss_reg_next        = mss_reg;
    stamp_regs_next     = stamp_regs;
    sack_count_next     = sack_count;
    sack_base_next      = sack_base;
    present_next        = present;
    bad_flag_next       = bad_flag;
    dup_flag_next       = dup_flag;
    inv_flag_next       = inv_flag;
    finish              = 1'b0;

    // New area: clear results and load the byte budget
    if (item.first_byte) begin
      scale_reg_next      = '0;
      mss_reg_next        = '0;
      stamp_regs_next     = '0;
      sack_count_next     = '0;
      sack_base_next      = '0;
      present_next        = '0;
      bad_flag_next       = 1'b0;
      dup_flag_next       = 1'b0;
      inv_flag_next       = 1'b0;
      bytes_left_next     = (item.area_length > 6'(MAX_OPTION_BYTES)) ?
                            6'(MAX_OPTION_BYTES) : item.area_length;
      area_position_next  = '0;
      current_kind_next   = '0;
      current_length_next = '0;
      data_index_next     = '0;
      data_capture_next   = '0;
      phase_next          = PH_KIND;
    end

    if (phase_next != PH_STOP && bytes_left_next != 6'd0) begin
      case (phase_next)
        PH_KIND: begin
          if (item.option_byte == KIND_EOL) begin
            phase_next = PH_STOP;
          end else if (item.option_byte == KIND_NOP) begin
            area_position_next = area_position_next + 6'd1;
            bytes_left_next    = bytes_left_next - 6'd1;
          end else if (bytes_left_next < 6'd2) begin
            phase_next = PH_STOP;
          end else begin
            current_kind_next = item.option_byte;
            phase_next        = PH_LEN;
          end
        end
        PH_LEN: begin
          if (item.option_byte > {2'b00, bytes_left_next} || item.option_byte < 8'd2) begin
            bad_flag_next = 1'b1;
            inv_flag_next = 1'b1;
            phase_next    = PH_STOP;
          end else begin
            current_length_next = item.option_byte[5:0];
            data_index_next     = '0;
            data_capture_next   = '0;
            if (item.option_byte == 8'd2) begin
              finish = 1'b1;
            end else begin
              phase_next = PH_DATA;
            end
          end
        end
        PH_DATA: begin
          // Keep the first eight data bytes, big-endian
          if (data_index_next < 6'd8) begin
            data_capture_next[{3'd7 - data_index_next[2:0], 3'b000} +: 8] = item.option_byte;
          end
          data_index_next = data_index_next + 6'd1;
          if (data_index_next >= current_length_next - 6'd2) begin
            finish = 1'b1;
          end
        end
        default: ;
      endcase
    end

    d0       = data_capture_next[63:56];
    d1       = data_capture_next[55:48];
    n        = current_length_next;
    n_minus2 = n - 6'd2;

    if (finish) begin
      case (current_kind_next)
        KIND_WS: begin
          if (n != 6'd3) bad_flag_next = 1'b1;
          else if (present_next[PM_WS]) dup_flag_next = 1'b1;
          else begin
            present_next[PM_WS] = 1'b1;
            scale_reg_next = (d0 <= {4'd0, MAX_WS_SHIFT}) ? d0[3:0] : 4'd0;
          end
        end
        KIND_MSS: begin
          if (n != 6'd4) bad_flag_next = 1'b1;
          else if (present_next[PM_MSS]) dup_flag_next = 1'b1;
          else begin
            present_next[PM_MSS] = 1'b1;
            mss_reg_next = {d0, d1};
          end
        end
        KIND_SACKOK: begin
          if (n != 6'd2) bad_flag_next = 1'b1;
          else if (present_next[PM_SACKOK]) dup_flag_next = 1'b1;
          else present_next[PM_SACKOK] = 1'b1;
        end
        KIND_TS: begin
          if (n != 6'd10) bad_flag_next = 1'b1;
          else if (present_next[PM_TS]) dup_flag_next = 1'b1;
          else begin
            present_next[PM_TS] = 1'b1;
            stamp_regs_next = data_capture_next;
          end
        end
        KIND_SACK: begin
          // An empty SACK is accepted and has no effect
          if (n != 6'd2) begin
            if (n < 6'd10 || n > 6'd34 || n_minus2[2:0] != 3'd0) bad_flag_next = 1'b1;
            else if (present_next[PM_SACK]) dup_flag_next = 1'b1;
            else begin
              present_next[PM_SACK] = 1'b1;
              sack_count_next = n_minus2[5:3];
              sack_base_next  = area_position_next + 6'(FIXED_HEADER_BYTES + 2);
            end
          end
        end
        KIND_TFO: begin
          if (n != 6'd2 && (n < 6'd6 || n > 6'd18 || n[0])) bad_flag_next = 1'b1;
          else if (present_next[PM_TFO]) dup_flag_next = 1'b1;
          else present_next[PM_TFO] = 1'b1;
        end
        KIND_EXP1, KIND_EXP2: begin
          if (n == 6'd4 || n == 6'd12) begin
            if ({d0, d1} == TFO_EXP_MAGIC) begin
              if (present_next[PM_TFO]) dup_flag_next = 1'b1;
              else present_next[PM_TFO] = 1'b1;
            end
          end else begin
            bad_flag_next = 1'b1;
          end
        end
        KIND_MD5: begin
          if (n != 6'd18) begin
            bad_flag_next = 1'b1;
            inv_flag_next = 1'b1;
          end else begin
            present_next[PM_MD5] = 1'b1;
          end
        end
        KIND_AO: begin
          if (n < 6'd4) begin
            bad_flag_next = 1'b1;
            inv_flag_next = 1'b1;
          end else begin
            present_next[PM_AO] = 1'b1;
          end
        end
        default: ;
      endcase
      area_position_next = area_position_next + n;
      bytes_left_next    = bytes_left_next - n;
      phase_next         = PH_KIND;
    end

    // The summary closes the area until the next first byte
    if (item.last_byte) begin
      phase_next      = PH_STOP;
      bytes_left_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_KIND;
      bytes_left     <= '0;
      area_position  <= '0;
      current_kind   <= '0;
      current_length <= '0;
      data_index     <= '0;
      data_capture   <= '0;
      scale_reg      <= '0;
      mss_reg        <= '0;
      stamp_regs     <= '0;
      sack_count     <= '0;
      sack_base      <= '0;
      present        <= '0;
      bad_flag       <= 1'b0;
      dup_flag       <= 1'b0;
      inv_flag       <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      area_position  <= area_position_next;
      current_kind   <= current_kind_next;
      current_length <= current_length_next;
      data_index     <= data_index_next;
      data_capture   <= data_capture_next;
      scale_reg      <= scale_reg_next;
      mss_reg        <= mss_reg_next;
      stamp_regs     <= stamp_regs_next;
      sack_count     <= sack_count_next;
      sack_base      <= sack_base_next;
      present        <= present_next;
      bad_flag       <= bad_flag_next;
      dup_flag       <= dup_flag_next;
      inv_flag       <= inv_flag_next;
    end
  end

  always_comb begin
    summary.window_scale     = scale_reg_next;
    summary.max_segment_size = mss_reg_next;
    summary.stamp_value      = stamp_regs_next[63:32];
    summary.stamp_echo       = stamp_regs_next[31:0];
    summary.sack_blocks      = sack_count_next;
    summary.sack_start       = sack_base_next;
    summary.present_mask     = present_next;
    summary.bad_length_seen  = bad_flag_next;
    summary.duplicate_seen   = dup_flag_next;
    summary.packet_invalid   = inv_flag_next;
  end

endmodule

// File: hdl/tcp_option_parser.sv
// Top level of the TCP option parser: input register, parser, result register.
//
// Usage: feed the TCP option area one byte per transaction on the input
// channel (option_byte, area_length, first_byte, last_byte; in_valid/in_stall).
// Mark the first byte of an area with first_byte, and give the area length on
// it; lengths above 40 saturate to 40. Mark the final byte with last_byte.
// Each byte marked last produces one summary transaction on the output
// channel (out_valid/out_stall); other bytes produce nothing.
// A byte accepted into the input register is parsed when the step advances,
// and on that parse step a last byte's summary enters the result register.
// Throughput: one byte per cycle unless a last byte waits for an untaken
// summary; the input register feeds the parse step into the result register.
// Stall: while the result register holds an untaken summary, the block keeps
// taking bytes that carry no last mark; a last byte waits in the input
// register, and in_stall rises only then, until the summary is taken.
// Reset (rst, synchronous): clears the valid flags, the parse state and the
// summary registers; bytes before any first byte are ignored, and a last byte
// then reports an all-zero summary.
module tcp_option_parser
  import tcpo_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  option_byte,
  input  logic [5:0]  area_length,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  window_scale,
  output logic [15:0] max_segment_size,
  output logic [31:0] stamp_value,
  output logic [31:0] stamp_echo,
  output logic [2:0]  sack_blocks,
  output logic [5:0]  sack_start,
  output logic [7:0]  present_mask,
  output logic        bad_length_seen,
  output logic        duplicate_seen,
  output logic        packet_invalid
);

  // Input register
  logic          held_valid;
  tcpo_item_t    held_item;

  // Result register
  tcpo_summary_t result;
  tcpo_summary_t summary;

  logic out_free;
  logic step;
  logic accept;

  // The result register is free when empty or being taken this cycle
  assign out_free = !out_valid || !out_stall;
  // Bytes without a last mark never wait for the output side
  assign step     = held_valid && (!held_item.last_byte || out_free);
  assign in_stall = held_valid && !step;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_item.option_byte <= option_byte;
      held_item.area_length <= area_length;
      held_item.first_byte  <= first_byte;
      held_item.last_byte   <= last_byte;
    end
  end

  tcpo_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .item    (held_item),
    .summary (summary)
  );

  // Load the summary on a last byte; drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && held_item.last_byte) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && held_item.last_byte) begin
      result <= summary;
    end
  end

  assign window_scale     = result.window_scale;
  assign max_segment_size = result.max_segment_size;
  assign stamp_value      = result.stamp_value;
  assign stamp_echo       = result.stamp_echo;
  assign sack_blocks      = result.sack_blocks;
  assign sack_start       = result.sack_start;
  assign present_mask     = result.present_mask;
  assign bad_length_seen  = result.bad_length_seen;
  assign duplicate_seen   = result.duplicate_seen;
  assign packet_invalid   = result.packet_invalid;

`ifndef NO_ASSERTIONS
  // A byte with no last mark never blocks the input side
  assert property (@(posedge clk) disable iff (rst)
    held_valid && !held_item.last_byte |-> !in_stall)
    else $error("input stalled on a byte without last mark");

  // Stall on the input only comes from a held result the receiver refuses
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall && held_valid && held_item.last_byte)
    else $error("input stalled without a blocked result");

  // A parsed last byte always presents a result on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    step && held_item.last_byte |=> out_valid)
    else $error("summary lost after last byte");

  // Window scale never reports a shift beyond the limit
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> window_scale <= MAX_WS_SHIFT)
    else $error("window scale above limit");
`endif

endmodule
